>>> rtl/isaac_pkg.sv
// ----------------------------------------------------------------------------
// isaac_pkg
// Shared constants, types and helper functions for the isaac word generator.
// ----------------------------------------------------------------------------
package isaac_pkg;

	localparam int MEM_WORDS   = 256;
	localparam int ADDR_W      = $clog2(MEM_WORDS);
	localparam int WORD_W      = 32;
	localparam int HALF_OFFSET = MEM_WORDS / 2;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [WORD_W-1:0] word_t;

	// request codes
	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_GEN  = 1'b1
	} req_t;

	// round sequencer, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_S1   = 4'b0010,
		ST_S2   = 4'b0100,
		ST_S3   = 4'b1000
	} state_t;

	localparam addr_t LAST_INDEX = addr_t'(MEM_WORDS - 1);
	localparam addr_t HALF_ADDR  = addr_t'(HALF_OFFSET);

	// accumulator shift-xor chosen by index mod 4
	function automatic word_t mix_acc(input word_t a, input logic [1:0] phase);
		word_t m;
		unique case (phase)
			2'd0: m = a ^ (a << 13);
			2'd1: m = a ^ (a >> 6);
			2'd2: m = a ^ (a << 2);
			default: m = a ^ (a >> 16);
		endcase
		return m;
	endfunction

endpackage

>>> rtl/isaac_word_generator.sv
// ----------------------------------------------------------------------------
// isaac_word_generator
// ISAAC-32 generator around a 256-word mix memory, one word per generate request.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid / in_stall): req_type selects a load, which
//   writes load_data at load_address, or a generate, which runs one round
//   at the internal word index and yields one word.
//   output channel (out_valid / out_stall): random_word and batch_last,
//   which is set on the word made at index 255.
// Timing:
//   a load writes load_data when it is accepted; loads may follow each
//   other every cycle while no round is running. A generate runs the
//   round steps S1, S2, S3; its word is registered as S3 ends and the
//   next item is accepted in S3, so rounds do not overlap. The dependent
//   read chain (entry i and i+128, then x[9:2], then y[17:10]) through
//   the mix memory's two read ports and one write port sets the steps.
// Reset:
//   accumulator, previous word, batch counter and word index clear; the
//   memory keeps its contents and must be loaded before generating.
// Stall:
//   a word waits in the output register; a round that finishes while it
//   is still held waits in its last step and the input is stalled.
// ----------------------------------------------------------------------------
module isaac_word_generator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  isaac_pkg::addr_t     load_address,
	input  isaac_pkg::word_t     load_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output isaac_pkg::word_t     random_word,
	output logic                 batch_last
);
	import isaac_pkg::*;

	// mix memory
	word_t mem_q [MEM_WORDS];

	state_t st_q;
	word_t  acc_q;
	word_t  prev_q;
	word_t  count_q;
	addr_t  index_q;

	addr_t  idx_s1;
	word_t  rd_a_q;
	word_t  rd_b_q;
	word_t  x_q;
	word_t  y_q;
	logic   fwd_q;

	logic   out_valid_q;
	word_t  out_word_q;
	logic   out_last_q;

	logic   done;
	logic   slot;
	logic   acc_in;
	logic   gen_in;
	logic   load_in;
	logic   rd_a_en;
	addr_t  rd_a_addr;
	addr_t  rd_b_addr;
	logic   wr_en;
	addr_t  wr_addr;
	word_t  wr_data;
	word_t  y_new;
	word_t  r_new;

	// handshake
	assign done    = (st_q == ST_S3) && (!out_valid_q || !out_stall);
	assign slot    = (st_q == ST_IDLE) || done;
	assign in_stall = !slot;
	assign acc_in  = in_valid && slot;
	assign gen_in  = acc_in && (req_type == REQ_GEN);
	assign load_in = acc_in && (req_type == REQ_LOAD);

	// round datapath
	assign y_new = rd_a_q + acc_q + prev_q;
	assign r_new = (fwd_q ? y_q : rd_a_q) + x_q;

	// memory port control
	always_comb begin
		rd_a_en   = 1'b0;
		rd_a_addr = index_q;
		if (gen_in) begin
			rd_a_en   = 1'b1;
			rd_a_addr = index_q;
		end else if (st_q == ST_S1) begin
			rd_a_en   = 1'b1;
			rd_a_addr = rd_a_q[ADDR_W+1:2];
		end else if (st_q == ST_S2) begin
			rd_a_en   = 1'b1;
			rd_a_addr = y_new[ADDR_W+9:10];
		end
	end

	assign rd_b_addr = index_q + HALF_ADDR;
	assign wr_en     = load_in || (st_q == ST_S2);
	assign wr_addr   = load_in ? load_address : idx_s1;
	assign wr_data   = load_in ? load_data : y_new;

	// memory write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// memory reads, registered
	always_ff @(posedge clk) begin
		if (rd_a_en) begin
			rd_a_q <= mem_q[rd_a_addr];
		end
		if (gen_in) begin
			rd_b_q <= mem_q[rd_b_addr];
		end
	end

	// round sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: if (gen_in) st_q <= ST_S1;
				ST_S1:   st_q <= ST_S2;
				ST_S2:   st_q <= ST_S3;
				ST_S3: begin
					if (done) st_q <= gen_in ? ST_S1 : ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			prev_q  <= '0;
			count_q <= '0;
			index_q <= '0;
		end else begin
			if (gen_in) begin
				index_q <= index_q + addr_t'(1);
			end
			if (st_q == ST_S1) begin
				acc_q <= mix_acc(acc_q, idx_s1[1:0]) + rd_b_q;
				if (idx_s1 == '0) begin
					count_q <= count_q + word_t'(1);
					prev_q  <= prev_q + count_q + word_t'(1);
				end
			end
			if (done) begin
				prev_q <= r_new;
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (gen_in) begin
			idx_s1 <= index_q;
		end
		if (st_q == ST_S1) begin
			x_q <= rd_a_q;
		end
		if (st_q == ST_S2) begin
			y_q   <= y_new;
			fwd_q <= (y_new[ADDR_W+9:10] == idx_s1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_word_q <= r_new;
			out_last_q <= (idx_s1 == LAST_INDEX);
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = out_word_q;
	assign batch_last  = out_last_q;

`ifndef SYNTHESIS
	// a generate always starts the round
	a_gen_starts: assert property (@(posedge clk) disable iff (!arst_n)
		gen_in |=> st_q == ST_S1)
		else $error("generate accepted without starting a round");

	// round step one advances to step two without a gap
	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_S1 |=> st_q == ST_S2)
		else $error("round step one did not advance");

	// no item enters while memory accesses of a round are in flight
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_S1 || st_q == ST_S2) |-> in_stall)
		else $error("input accepted during an active round");

	// a finished round presents a word
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid)
		else $error("finished round left no word");
`endif

endmodule
